// ----- hw/rtl/wcot_pkg.sv -----
// Shared types and constants for the window channel-occupancy trigger.
// No dependencies; the top level, wcot_front and wcot_back use it by scoped names.
package wcot_pkg;

  localparam int unsigned THRESH_W = 12;
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned SRC_W    = 16;
  localparam int unsigned PROD_W   = THRESH_W + SRC_W;
  localparam int unsigned WIN_W    = 64;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned CRATE_W  = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [7:0]          FIBER_IGNORED = 8'd2;
  localparam logic [THRESH_W-1:0] THRESH_RESET  = 12'd85;
  localparam logic [SRC_W-1:0]    SRC_MAX       = 16'hffff;

  // register select, taken from paddr bit 2
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_BASE   = 1'b1;

  // set header carried from front to back
  typedef struct packed {
    logic               first;
    logic               mark;
    logic [CRATE_W-1:0] crate;
    logic [WIN_W-1:0]   wstart;
  } cmd_hdr_t;

  // trigger transaction
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [CRATE_W-1:0] crate;
    logic [WIN_W-1:0]   time_stamp;
  } trig_t;

endpackage

// ----- hw/rtl/wcot_prim_if.sv -----
// Primitive input channel: valid/ready handshake with one trigger primitive.
// Depends on nothing.
interface wcot_prim_if;
  logic        valid;
  logic        ready;
  logic [31:0] detector_id;
  logic [63:0] window_start;
  logic [31:0] channel;
  logic        has_primitive;
  logic        first_of_set;

  modport source (output valid, detector_id, window_start, channel, has_primitive,
                  first_of_set, input ready);
  modport sink   (input valid, detector_id, window_start, channel, has_primitive,
                  first_of_set, output ready);
endinterface

// ----- hw/rtl/wcot_trig_if.sv -----
// Trigger output channel: valid/ready handshake with one trigger record.
// Depends on nothing.
interface wcot_trig_if;
  logic        valid;
  logic        ready;
  logic [31:0] trigger_number;
  logic [7:0]  crate;
  logic [63:0] trigger_time;

  modport source (output valid, trigger_number, crate, trigger_time, input ready);
  modport sink   (input valid, trigger_number, crate, trigger_time, output ready);
endinterface

// ----- hw/rtl/window_channel_occupancy_trigger_top.sv -----
// Top level of the window channel-occupancy trigger.
// Uses wcot_pkg, wcot_prim_if, wcot_trig_if, wcot_fifo, wcot_front, wcot_back.
//
// Usage:
//   prim carries trigger primitives (valid/ready); a transaction is taken when
//   both are high. trig carries trigger records the same way. The APB port
//   writes hits_threshold (0x0) and channel_base (0x4); write only while idle.
//   Throughput is one primitive per cycle while prim.ready is high, set by the
//   single read-modify-write of the hit map RAM per cycle (same-address
//   back-to-back hits forwarded). A trigger passes the command queue, the back
//   end's second stage and the trigger queue; the command queue separates the
//   front end from the back end, and the trigger queue of OUT_DEPTH entries
//   separates the back end from trig. When trig stalls, the trigger queue
//   fills, the back end holds, then the command queue fills and prim.ready
//   drops; nothing is lost. After reset the hit map is swept clear with
//   prim.ready low; configuration writes are taken during the sweep. Registers
//   return to 85 and 0, all counts and the trigger number to zero.
module window_channel_occupancy_trigger_top #(
  parameter int unsigned CHANNELS    = 4096,
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned OUT_DEPTH   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  wcot_prim_if.sink                     prim,
  wcot_trig_if.source                   trig,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcot_pkg::ADDR_W-1:0]   paddr,
  input  logic [wcot_pkg::DATA_W-1:0]   pwdata,
  output logic [wcot_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned AW   = $clog2(CHANNELS);
  localparam int unsigned HDRW = $bits(wcot_pkg::cmd_hdr_t);
  localparam int unsigned QW   = HDRW + AW;
  localparam int unsigned TW   = $bits(wcot_pkg::trig_t);

  logic [wcot_pkg::THRESH_W-1:0] hits_threshold;
  logic [wcot_pkg::BASE_W-1:0]   channel_base;

  logic                          f_push;
  wcot_pkg::cmd_hdr_t            f_hdr;
  logic [AW-1:0]                 f_addr;
  logic                          q_full;
  logic                          q_empty;
  logic [QW-1:0]                 q_head;
  logic                          q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  wcot_pkg::cmd_hdr_t            q_hdr;
  logic [AW-1:0]                 q_addr;
  logic                          sweeping;

  logic                          o_push;
  wcot_pkg::trig_t               o_data;
  wcot_pkg::trig_t               o_head;
  logic [TW-1:0]                 o_head_bits;
  logic                          o_full;
  logic                          o_empty;
  logic [$clog2(OUT_DEPTH+1)-1:0] o_count;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_threshold <= wcot_pkg::THRESH_RESET;
      channel_base   <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        wcot_pkg::REG_THRESH: hits_threshold <= pwdata[wcot_pkg::THRESH_W-1:0];
        wcot_pkg::REG_BASE:   channel_base   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      wcot_pkg::REG_THRESH: prdata = wcot_pkg::DATA_W'(hits_threshold);
      wcot_pkg::REG_BASE:   prdata = channel_base;
      default:              prdata = '0;
    endcase
  end

  wcot_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .prim         (prim),
    .channel_base (channel_base),
    .run          (!sweeping),
    .queue_full   (q_full),
    .push         (f_push),
    .hdr          (f_hdr),
    .addr         (f_addr)
  );

  wcot_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_hdr, f_addr}),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  assign q_hdr  = q_head[QW-1:AW];
  assign q_addr = q_head[AW-1:0];

  wcot_back #(
    .CHANNELS  (CHANNELS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .hits_threshold (hits_threshold),
    .q_empty        (q_empty),
    .q_hdr          (q_hdr),
    .q_addr         (q_addr),
    .pop            (q_pop),
    .out_count      (o_count),
    .out_push       (o_push),
    .out_data       (o_data),
    .sweeping       (sweeping)
  );

  wcot_fifo #(
    .WIDTH (TW),
    .DEPTH (OUT_DEPTH)
  ) u_trig_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push && !o_full),
    .wdata (o_data),
    .pop   (trig.valid && trig.ready),
    .rdata (o_head_bits),
    .full  (o_full),
    .empty (o_empty),
    .count (o_count)
  );

  assign o_head              = o_head_bits;
  assign trig.valid          = !o_empty;
  assign trig.trigger_number = o_head.seq;
  assign trig.crate          = o_head.crate;
  assign trig.trigger_time   = o_head.time_stamp;

endmodule

// ----- hw/rtl/wcot_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wcot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/wcot_fifo.sv -----
// Small register FIFO with combinational head, used for the command and
// trigger queues. No dependencies.
module wcot_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign rdata = slots[rd_ptr];
  assign full  = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/wcot_front.sv -----
// Front end: takes primitive transactions, drops ignored sets and
// classifies the channel against the channel_base range. Uses wcot_pkg, wcot_prim_if.
module wcot_front #(
  parameter int unsigned CHANNELS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  wcot_prim_if.sink                     prim,
  input  logic [wcot_pkg::BASE_W-1:0]   channel_base,
  input  logic                          run,
  input  logic                          queue_full,
  output logic                          push,
  output wcot_pkg::cmd_hdr_t            hdr,
  output logic [$clog2(CHANNELS)-1:0]   addr
);

  localparam int unsigned AW = $clog2(CHANNELS);

  logic                        set_ignored;
  logic                        accept;
  logic                        fiber_ignored;
  logic [wcot_pkg::BASE_W-1:0] offset;
  logic                        in_range;

  assign prim.ready    = run && !queue_full;
  assign accept        = prim.valid && prim.ready;
  assign fiber_ignored = (prim.detector_id[23:16] == wcot_pkg::FIBER_IGNORED);
  assign offset        = prim.channel - channel_base;
  assign in_range      = (offset < wcot_pkg::BASE_W'(CHANNELS));

  assign push = accept && (prim.first_of_set ? !fiber_ignored : !set_ignored);
  assign addr = offset[AW-1:0];

  always_comb begin
    hdr        = '0;
    hdr.first  = prim.first_of_set;
    hdr.mark   = prim.has_primitive && in_range;
    hdr.crate  = prim.detector_id[7:0];
    hdr.wstart = prim.window_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_ignored <= 1'b0;
    end else if (accept && prim.first_of_set) begin
      set_ignored <= fiber_ignored;
    end
  end

endmodule

// ----- hw/rtl/wcot_back.sv -----
// Back end: window tracking, hit map lookup and update, threshold test.
// Uses wcot_pkg and wcot_ram; the hit map holds a valid bit and window tag.
module wcot_back #(
  parameter int unsigned CHANNELS  = 4096,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [wcot_pkg::THRESH_W-1:0]       hits_threshold,
  input  logic                                q_empty,
  input  wcot_pkg::cmd_hdr_t                  q_hdr,
  input  logic [$clog2(CHANNELS)-1:0]         q_addr,
  output logic                                pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
  output logic                                out_push,
  output wcot_pkg::trig_t                     out_data,
  output logic                                sweeping
);

  localparam int unsigned AW  = $clog2(CHANNELS);
  localparam int unsigned HCW = $clog2(CHANNELS + 1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned EW  = wcot_pkg::WIN_W + 1;

  logic [AW-1:0]                 sweep_addr;
  logic                          b2_valid;
  wcot_pkg::cmd_hdr_t            b2_hdr;
  logic [AW-1:0]                 b2_addr;
  logic [wcot_pkg::WIN_W-1:0]    cur_win;
  logic [HCW-1:0]                hit_count;
  logic [wcot_pkg::SRC_W-1:0]    sources;
  logic [wcot_pkg::SRC_W-1:0]    max_sources;
  logic [wcot_pkg::PROD_W-1:0]   needed;
  logic [wcot_pkg::SEQ_W-1:0]    seq;
  logic                          fwd_valid;
  logic [AW-1:0]                 fwd_addr;
  logic [wcot_pkg::WIN_W-1:0]    fwd_tag;

  logic [wcot_pkg::WIN_W-1:0]    cur_win_next;
  logic [HCW-1:0]                hit_count_next;
  logic [wcot_pkg::SRC_W-1:0]    sources_next;
  logic [wcot_pkg::SRC_W-1:0]    max_sources_next;
  logic [wcot_pkg::PROD_W-1:0]   needed_next;
  logic [wcot_pkg::PROD_W-1:0]   product;

  logic                          change;
  logic                          fire;
  logic                          hit;
  logic                          newly;
  logic [wcot_pkg::SRC_W-1:0]    src_base;
  logic [HCW-1:0]                cnt_base;
  logic                          m_inc;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [EW-1:0]                 ram_wdata;
  logic [EW-1:0]                 ram_rdata;

  wcot_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_hit_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  // one slot is held for the transaction in the second stage
  assign pop = !q_empty && !sweeping &&
               (({1'b0, out_count} + (OCW + 1)'(b2_valid)) < (OCW + 1)'(OUT_DEPTH));

  assign change = b2_valid && b2_hdr.first && (b2_hdr.wstart > cur_win);
  assign fire   = change && (wcot_pkg::PROD_W'(hit_count) >= needed);

  assign cur_win_next = change ? b2_hdr.wstart : cur_win;

  // entry is set only if tagged with the live window; the previous write is forwarded
  assign hit = (ram_rdata[EW-1] && (ram_rdata[EW-2:0] == cur_win_next)) ||
               (fwd_valid && (fwd_addr == b2_addr) && (fwd_tag == cur_win_next));
  assign newly = b2_valid && b2_hdr.mark && !hit;

  assign product = hits_threshold * max_sources;

  always_comb begin
    cnt_base         = change ? '0 : hit_count;
    src_base         = change ? '0 : sources;
    hit_count_next   = cnt_base + HCW'(newly);
    sources_next     = sources;
    max_sources_next = max_sources;
    m_inc            = 1'b0;
    needed_next      = product;
    if (b2_valid) begin
      sources_next = src_base;
      if (b2_hdr.first && (src_base != wcot_pkg::SRC_MAX)) begin
        sources_next = src_base + 1'b1;
      end
      m_inc            = (sources_next > max_sources);
      max_sources_next = m_inc ? sources_next : max_sources;
      needed_next      = m_inc ? needed + wcot_pkg::PROD_W'(hits_threshold) : needed;
    end
  end

  always_comb begin
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = newly;
      ram_waddr = b2_addr;
      ram_wdata = {1'b1, cur_win_next};
    end
  end

  assign out_push         = fire;
  assign out_data.seq        = seq;
  assign out_data.crate      = b2_hdr.crate;
  assign out_data.time_stamp = cur_win;

  always_ff @(posedge clk) begin
    if (pop) begin
      b2_hdr  <= q_hdr;
      b2_addr <= q_addr;
    end
    fwd_addr <= b2_addr;
    fwd_tag  <= cur_win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping    <= 1'b1;
      sweep_addr  <= '0;
      b2_valid    <= 1'b0;
      cur_win     <= '0;
      hit_count   <= '0;
      sources     <= '0;
      max_sources <= '0;
      needed      <= '0;
      seq         <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      if (sweeping) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == AW'(CHANNELS - 1)) begin
          sweeping <= 1'b0;
        end
      end
      b2_valid    <= pop;
      cur_win     <= cur_win_next;
      hit_count   <= hit_count_next;
      sources     <= sources_next;
      max_sources <= max_sources_next;
      needed      <= needed_next;
      fwd_valid   <= newly;
      if (fire) begin
        seq <= seq + 1'b1;
      end
    end
  end

endmodule
